@@ sv/p2cb_pkg.sv @@
// Shared types, constants and helper functions of the polyline to Bezier converter.
// Used by every module of the block but p2cb_fifo; depends on nothing else.
package p2cb_pkg;

	localparam int NUM_AXES = 3;

	typedef logic [1:0] ctrl_num_t;

	localparam ctrl_num_t CTRL_START = 2'd0;
	localparam ctrl_num_t CTRL_END   = 2'd3;

	typedef struct packed {
		logic first;
		logic closing;
		logic last;
	} seg_flags_t;

	// Doubling steps of the shift-add reciprocal multiply for an iw-bit signed dividend.
	function automatic int div3_tree_steps(input int iw);
		return $clog2(iw + 2) - 1;
	endfunction

	// Cycles from an enabled input of the divide-by-three unit to its registered quotient.
	function automatic int div3_latency(input int iw);
		return div3_tree_steps(iw) + 2;
	endfunction

endpackage

@@ sv/p2cb_front.sv @@
// Input side: takes points, keeps the last two, and issues segment jobs.
// Depends on p2cb_pkg; feeds the job queue (p2cb_fifo).
module p2cb_front
	#(
	parameter int CW = 32,
	localparam int PW = p2cb_pkg::NUM_AXES * CW,
	localparam int JW = 3 * PW + $bits(p2cb_pkg::seg_flags_t)
	)
	(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [PW-1:0] in_point,
	input  logic          in_final,
	output logic          job_push,
	output logic [JW-1:0] job_data,
	input  logic          job_full
	);

	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_ONE  = 2'd1;
	localparam logic [1:0] HELD_TWO  = 2'd2;

	logic [1:0]            held_q;
	logic                  first_q;
	logic                  pend_q;
	logic [PW-1:0]         earlier_q;
	logic [PW-1:0]         current_q;
	logic                  accept;
	p2cb_pkg::seg_flags_t  flags;

	assign in_ready = !pend_q && !job_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		job_push      = 1'b0;
		flags.first   = 1'b0;
		flags.closing = 1'b1;
		flags.last    = 1'b1;
		job_data      = {flags, current_q, current_q, earlier_q};
		if (pend_q) begin
			job_push = !job_full;
		end else if (accept) begin
			unique case (held_q)
				HELD_ONE: begin
					job_push      = in_final;
					flags.first   = first_q;
					job_data      = {flags, in_point, in_point, current_q};
				end
				HELD_TWO: begin
					job_push      = 1'b1;
					flags.first   = first_q;
					flags.closing = 1'b0;
					flags.last    = !in_final;
					job_data      = {flags, in_point, current_q, earlier_q};
				end
				default: begin
					job_push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= HELD_NONE;
			first_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			if (pend_q && !job_full) begin
				pend_q <= 1'b0;
			end
			if (accept) begin
				unique case (held_q)
					HELD_ONE: begin
						held_q <= in_final ? HELD_NONE : HELD_TWO;
					end
					HELD_TWO: begin
						first_q <= 1'b0;
						if (in_final) begin
							held_q <= HELD_NONE;
							pend_q <= 1'b1;
						end
					end
					default: begin
						first_q <= 1'b1;
						held_q  <= in_final ? HELD_NONE : HELD_ONE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			current_q <= in_point;
			if (held_q == HELD_ONE || held_q == HELD_TWO) begin
				earlier_q <= current_q;
			end
		end
	end

endmodule

@@ sv/p2cb_fifo.sv @@
// Short register queue that carries segment jobs from the input side to the output side.
// Depends on nothing else.
module p2cb_fifo
	#(
	parameter int W     = 8,
	parameter int DEPTH = 4
	)
	(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic         rvalid,
	output logic [W-1:0] rdata
	);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0]   cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full   = cnt_q == (AW + 1)'(DEPTH);
	assign rvalid = cnt_q != '0;
	assign rdata  = mem_q[rp_q];
	assign do_wr  = wr && !full;
	assign do_rd  = rd && rvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

@@ sv/p2cb_div3.sv @@
// Pipelined floor division of a signed value by three, by a shift-add reciprocal multiply.
// Depends on p2cb_pkg for its stage count.
module p2cb_div3
	#(
	parameter int IW = 33
	)
	(
	input  logic          clk,
	input  logic          en,
	input  logic [IW-1:0] x,
	output logic [IW-1:0] q
	);

	localparam int YW = IW + 1;
	localparam int KL = p2cb_pkg::div3_tree_steps(IW);
	localparam int S  = 2 ** (KL + 1);
	localparam int MW = YW + S;
	localparam logic [YW-1:0] BIAS = YW'(3) << (IW - 1);

	logic [YW-1:0] y_w;
	logic [YW-1:0] y_s1;
	logic [MW-1:0] acc_s1;
	logic [YW-1:0] y_s2   [KL];
	logic [MW-1:0] acc_s2 [KL];
	logic [MW-1:0] prod_w;
	logic [IW-1:0] quo_w;
	logic [IW-1:0] q_s3;

	// The bias makes the dividend positive; it adds exactly 2^(IW-1) to the quotient.
	assign y_w    = {x[IW-1], x} + BIAS;
	assign prod_w = acc_s2[KL-1] + MW'(y_s2[KL-1]);
	assign quo_w  = prod_w[S +: IW];
	assign q      = q_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1      <= y_w;
			acc_s1    <= MW'(y_w);
			y_s2[0]   <= y_s1;
			acc_s2[0] <= acc_s1 + (acc_s1 << 2);
			for (int j = 1; j < KL; j++) begin
				y_s2[j]   <= y_s2[j-1];
				acc_s2[j] <= acc_s2[j-1] + (acc_s2[j-1] << (2 << j));
			end
			q_s3 <= {~quo_w[IW-1], quo_w[IW-2:0]};
		end
	end

endmodule

@@ sv/p2cb_back.sv @@
// Output side: turns segment jobs into four control points and sends them one per transfer.
// Depends on p2cb_pkg and p2cb_div3.
module p2cb_back
	#(
	parameter int CW = 32,
	localparam int PW = p2cb_pkg::NUM_AXES * CW,
	localparam int JW = 3 * PW + $bits(p2cb_pkg::seg_flags_t)
	)
	(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  logic [JW-1:0]       job_data,
	output logic                job_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [PW-1:0]       out_point,
	output p2cb_pkg::ctrl_num_t out_ctrl,
	output logic                out_closing,
	output logic                out_last
	);

	localparam int NA  = p2cb_pkg::NUM_AXES;
	localparam int DW  = CW + 1;
	localparam int LAT = p2cb_pkg::div3_latency(DW);

	logic                 adv;
	logic                 load;
	logic [PW-1:0]        prev_in;
	logic [PW-1:0]        cur_in;
	logic [PW-1:0]        next_in;
	p2cb_pkg::seg_flags_t flags_in;

	logic                 v_s1;
	logic [PW-1:0]        prev_s1;
	logic [PW-1:0]        cur_s1;
	p2cb_pkg::seg_flags_t flags_s1;
	logic [DW-1:0]        d_s1 [NA];
	logic [DW-1:0]        e_s1 [NA];

	logic [DW-1:0]        qd [NA];
	logic [DW-1:0]        qe [NA];

	logic                 v_s2     [LAT];
	logic [PW-1:0]        prev_s2  [LAT];
	logic [PW-1:0]        cur_s2   [LAT];
	logic [2*NA-1:0]      dlo_s2   [LAT];
	p2cb_pkg::seg_flags_t flags_s2 [LAT];

	logic [PW-1:0]        c1_w;
	logic [PW-1:0]        c3_w;
	logic [PW-1:0]        t_w;

	logic                 v_s3;
	logic [PW-1:0]        c1_s3;
	logic [PW-1:0]        c3_s3;
	logic [PW-1:0]        t_s3;
	logic [PW-1:0]        prev_s3;
	logic [PW-1:0]        cur_s3;
	p2cb_pkg::seg_flags_t flags_s3;

	logic [PW-1:0]        c4_w;
	logic [PW-1:0]        ctrl0_w;

	logic [PW-1:0]        seg_q [4];
	logic [PW-1:0]        end_q;
	p2cb_pkg::ctrl_num_t  idx_q;
	logic                 busy_q;
	logic                 closing_q;
	logic                 last_q;

	assign prev_in  = job_data[PW-1:0];
	assign cur_in   = job_data[2*PW-1:PW];
	assign next_in  = job_data[3*PW-1:2*PW];
	assign flags_in = p2cb_pkg::seg_flags_t'(job_data[JW-1:3*PW]);

	// The whole compute pipeline holds while its last stage waits for the serializer.
	assign load    = v_s3 && (!busy_q || (out_ready && idx_q == p2cb_pkg::CTRL_END));
	assign adv     = !v_s3 || load;
	assign job_pop = adv && job_valid;

	genvar g;
	generate
		for (g = 0; g < NA; g++) begin : g_axis
			p2cb_div3 #(.IW(DW)) u_div_d (
				.clk (clk),
				.en  (adv),
				.x   (d_s1[g]),
				.q   (qd[g])
			);
			p2cb_div3 #(.IW(DW)) u_div_e (
				.clk (clk),
				.en  (adv),
				.x   (e_s1[g]),
				.q   (qe[g])
			);
		end
	endgenerate

	always_comb begin
		logic [CW-1:0] pv;
		logic [CW-1:0] cv;
		logic [DW-1:0] qdv;
		logic [DW-1:0] qev;
		logic [1:0]    rem;
		logic [DW:0]   sum1;
		logic [DW:0]   sum3;
		logic [DW:0]   sumt;
		for (int c = 0; c < NA; c++) begin
			pv   = prev_s2[LAT-1][c*CW +: CW];
			cv   = cur_s2[LAT-1][c*CW +: CW];
			qdv  = qd[c];
			qev  = qe[c];
			rem  = dlo_s2[LAT-1][2*c +: 2] - qdv[1:0] - {qdv[0], 1'b0};
			sum1 = {pv[CW-1], pv[CW-1], pv} + {qdv[DW-1], qdv};
			sum3 = {pv[CW-1], pv[CW-1], pv} + {qdv, 1'b0} + (DW + 1)'(rem == 2'd2);
			sumt = {cv[CW-1], cv[CW-1], cv} + {qev[DW-1], qev};
			c1_w[c*CW +: CW] = sum1[CW-1:0];
			c3_w[c*CW +: CW] = sum3[CW-1:0];
			t_w[c*CW +: CW]  = sumt[CW-1:0];
		end
	end

	always_comb begin
		logic [CW-1:0] c3v;
		logic [CW-1:0] tv;
		logic [CW:0]   mid;
		for (int c = 0; c < NA; c++) begin
			c3v = c3_s3[c*CW +: CW];
			tv  = t_s3[c*CW +: CW];
			mid = {c3v[CW-1], c3v} + {tv[CW-1], tv};
			c4_w[c*CW +: CW] = flags_s3.closing ? cur_s3[c*CW +: CW] : mid[CW:1];
		end
		ctrl0_w = flags_s3.first ? prev_s3 : end_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k < LAT; k++) begin
				v_s2[k] <= 1'b0;
			end
			v_s3   <= 1'b0;
			busy_q <= 1'b0;
			idx_q  <= p2cb_pkg::CTRL_START;
		end else begin
			if (adv) begin
				v_s1    <= job_valid;
				v_s2[0] <= v_s1;
				for (int k = 1; k < LAT; k++) begin
					v_s2[k] <= v_s2[k-1];
				end
				v_s3 <= v_s2[LAT-1];
			end
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= p2cb_pkg::CTRL_START;
			end else if (busy_q && out_ready) begin
				if (idx_q == p2cb_pkg::CTRL_END) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prev_s1  <= prev_in;
			cur_s1   <= cur_in;
			flags_s1 <= flags_in;
			for (int c = 0; c < NA; c++) begin
				d_s1[c] <= {cur_in[c*CW+CW-1], cur_in[c*CW +: CW]}
					- {prev_in[c*CW+CW-1], prev_in[c*CW +: CW]};
				e_s1[c] <= {next_in[c*CW+CW-1], next_in[c*CW +: CW]}
					- {cur_in[c*CW+CW-1], cur_in[c*CW +: CW]};
				dlo_s2[0][2*c +: 2] <= d_s1[c][1:0];
			end
			prev_s2[0]  <= prev_s1;
			cur_s2[0]   <= cur_s1;
			flags_s2[0] <= flags_s1;
			for (int k = 1; k < LAT; k++) begin
				prev_s2[k]  <= prev_s2[k-1];
				cur_s2[k]   <= cur_s2[k-1];
				dlo_s2[k]   <= dlo_s2[k-1];
				flags_s2[k] <= flags_s2[k-1];
			end
			c1_s3    <= c1_w;
			c3_s3    <= c3_w;
			t_s3     <= t_w;
			prev_s3  <= prev_s2[LAT-1];
			cur_s3   <= cur_s2[LAT-1];
			flags_s3 <= flags_s2[LAT-1];
		end
		if (load) begin
			seg_q[0]  <= ctrl0_w;
			seg_q[1]  <= c1_s3;
			seg_q[2]  <= c3_s3;
			seg_q[3]  <= c4_w;
			end_q     <= c4_w;
			closing_q <= flags_s3.closing;
			last_q    <= flags_s3.last;
		end
	end

	assign out_valid   = busy_q;
	assign out_point   = seg_q[idx_q];
	assign out_ctrl    = idx_q;
	assign out_closing = closing_q;
	assign out_last    = last_q && idx_q == p2cb_pkg::CTRL_END;

endmodule

@@ sv/polyline_to_cubic_bezier.sv @@
// Top level of the polyline to piecewise cubic Bezier converter.
// Depends on p2cb_pkg, p2cb_front, p2cb_fifo, p2cb_div3 and p2cb_back.
//
// Input stream (s_axis): one polyline point per transfer, tlast on the last point.
// Output stream (m_axis): one control point per transfer, four per segment in order,
// tuser carries the place in the segment and the closing-segment flag, and tlast marks
// the last control point caused by an input point.
// A segment is sent once the point after its end arrives, or at once on a final point;
// a final point behind two buffered points gives two segments (eight transfers), and a
// lone final point gives none.
// Throughput: one output transfer per cycle while m_axis_tready is high, four transfers per
// segment; the output serializer sets this figure, and points are taken at the segment rate.
// Path: a segment job goes from the input transfer through the job queue, the first compute
// stage, the divide-by-three pipeline, the third stage and the segment register to the
// first control point. Up to JOB_DEPTH segments wait in the job queue.
// When the receiver stalls, the output holds, the compute pipeline holds, the job queue
// fills and then s_axis_tready falls. Reset empties the point buffer, the queue and the
// pipeline; the next point starts a new curve.
module polyline_to_cubic_bezier
	#(
	parameter int COORD_WIDTH = 32,
	parameter int JOB_DEPTH   = 4,
	localparam int PW         = p2cb_pkg::NUM_AXES * COORD_WIDTH,
	localparam int TDATA_W    = ((PW + 7) / 8) * 8
	)
	(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,  // px, py, pz, zero padding
	input  logic               s_axis_tlast,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,  // qx, qy, qz, zero padding
	output logic [2:0]         m_axis_tuser,  // ctrl_number[1:0], closing_segment
	output logic               m_axis_tlast
	);

	localparam int JW = 3 * PW + $bits(p2cb_pkg::seg_flags_t);

	logic                job_push;
	logic [JW-1:0]       job_wdata;
	logic                job_full;
	logic                job_pop;
	logic                job_valid;
	logic [JW-1:0]       job_rdata;
	logic [PW-1:0]       out_point;
	p2cb_pkg::ctrl_num_t out_ctrl;
	logic                out_closing;

	p2cb_front #(.CW(COORD_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_point (s_axis_tdata[PW-1:0]),
		.in_final (s_axis_tlast),
		.job_push (job_push),
		.job_data (job_wdata),
		.job_full (job_full)
	);

	p2cb_fifo #(.W(JW), .DEPTH(JOB_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wdata  (job_wdata),
		.full   (job_full),
		.rd     (job_pop),
		.rvalid (job_valid),
		.rdata  (job_rdata)
	);

	p2cb_back #(.CW(COORD_WIDTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job_data    (job_rdata),
		.job_pop     (job_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_point   (out_point),
		.out_ctrl    (out_ctrl),
		.out_closing (out_closing),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = TDATA_W'(out_point);
	assign m_axis_tuser = {out_closing, out_ctrl};

	a_no_push_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("Segment job written into a full queue.");

	a_last_ends_segment : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1:0] == p2cb_pkg::CTRL_END)
		else $error("Run end flagged before the segment's last control point.");

	a_ctrl_in_order : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser[1:0] != p2cb_pkg::CTRL_END
		|=> m_axis_tvalid && m_axis_tuser[1:0] == 2'($past(m_axis_tuser[1:0]) + 2'd1))
		else $error("Control points of a segment left out of order.");

	a_closing_steady : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser[1:0] != p2cb_pkg::CTRL_END
		|=> $stable(m_axis_tuser[2]))
		else $error("Closing flag changed inside a segment.");

endmodule
